### design/nzm_pkg.sv
// Shared types, constants and helper functions for the nonzero-mean 3x3 filter.
// No dependencies; every other design file imports this package.
package nzm_pkg;

  // Pixel and register geometry
  localparam int PIXEL_BITS      = 16;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int COL_BITS        = 12;   // column field, fits the largest supported row
  localparam int ROW_BITS        = 12;   // output row counter, rows 0..4095
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int HEIGHT_LIMIT    = 4096;
  localparam int WIN             = 3;

  // Config port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Arithmetic widths in the back end
  localparam int COLSUM_BITS = 18;                        // three pixels
  localparam int SUM_BITS    = 20;                        // nine pixels
  localparam int ABS_BITS    = 19;                        // |sum| <= 9 * 2^15
  localparam int CNT_BITS    = 4;                         // 0..9
  localparam int RECIP_SHIFT = ABS_BITS + CNT_BITS;       // exact floor for divisors up to 9
  localparam int RECIP_BITS  = RECIP_SHIFT + 1;
  localparam int PROD_BITS   = ABS_BITS + RECIP_BITS;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // One classified item handed from front to back
  typedef struct packed {
    logic                clear_win;  // frame restarted: window starts empty
    logic                emit;       // this item produces a result
    logic                last;       // result is the last of the frame
    logic                col_lo_ok;  // left neighbor column inside the image
    logic                col_hi_ok;  // right neighbor column inside the image
    logic                row_lo_ok;  // upper neighbor row inside the image
    logic                row_hi_ok;  // lower neighbor row inside the image
    logic [COL_BITS-1:0] col;        // row store address
    pixel_t              pix;        // pixel shifted in (zero past the image)
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WIN,
    B_SUM,
    B_TOT,
    B_MUL,
    B_OUT
  } back_state_e;

  // ceil(2^RECIP_SHIFT / cnt); zero count gives a zero mean
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
    logic [RECIP_BITS-1:0] r;
    case (cnt)
      4'd1:    r = RECIP_BITS'(8388608);
      4'd2:    r = RECIP_BITS'(4194304);
      4'd3:    r = RECIP_BITS'(2796203);
      4'd4:    r = RECIP_BITS'(2097152);
      4'd5:    r = RECIP_BITS'(1677722);
      4'd6:    r = RECIP_BITS'(1398102);
      4'd7:    r = RECIP_BITS'(1198373);
      4'd8:    r = RECIP_BITS'(1048576);
      4'd9:    r = RECIP_BITS'(932068);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/nzm_front.sv
// Front end: accepts stream items, tracks frame position and classifies each item.
// Depends on nzm_pkg; pushes entry_t items into nzm_queue.
module nzm_front #(
  parameter int MAX_WIDTH = nzm_pkg::MAX_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [nzm_pkg::WIDTH_REG_BITS-1:0]     width_reg_i,
  input  logic [nzm_pkg::HEIGHT_REG_BITS-1:0]    height_reg_i,
  input  logic                                   cfg_write_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   in_kind_i,
  input  nzm_pkg::pixel_t                        in_pixel_i,
  input  logic                                   q_full_i,
  output logic                                   q_push_o,
  output nzm_pkg::entry_t                        q_data_o
);
  import nzm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int HW = HEIGHT_REG_BITS;
  localparam int TW = WW + HW;
  localparam int PW = TW + 1;

  logic [WW-1:0]       w_eff, w_q;
  logic [HW-1:0]       h_eff, h_q;
  logic [TW-1:0]       total_q;
  logic                settle_q;
  logic [PW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       col_q, col_d;
  logic [CW-1:0]       ocol_q, ocol_d;
  logic [ROW_BITS-1:0] orow_q, orow_d;
  logic                restart_q, restart_d;
  logic                accept, in_frame, ignore, emit, last;
  logic                col_end, ocol_end, orow_end;

  // Clamp the configured sizes
  always_comb begin
    if (width_reg_i == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_reg_i) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_reg_i);
    end
    if (height_reg_i == '0) begin
      h_eff = HW'(1);
    end else if (height_reg_i > HW'(HEIGHT_LIMIT)) begin
      h_eff = HW'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_reg_i;
    end
  end

  // Registered geometry; one idle cycle after a write lets it settle
  always_ff @(posedge clk_i) begin
    w_q     <= w_eff;
    h_q     <= h_eff;
    total_q <= TW'(w_eff) * TW'(h_eff);
  end

  // Classification
  assign in_ready_o = !q_full_i && !settle_q;
  assign accept     = in_valid_i && in_ready_o;
  assign in_frame   = pos_q < PW'(total_q);
  assign ignore     = in_frame && (kind_e'(in_kind_i) == KIND_DRAIN);
  assign q_push_o   = accept && !ignore;
  assign emit       = pos_q > PW'(w_q);
  assign last       = pos_q == (PW'(total_q) + PW'(w_q));
  assign col_end    = WW'(col_q) == (w_q - WW'(1));
  assign ocol_end   = WW'(ocol_q) == (w_q - WW'(1));
  assign orow_end   = HW'(orow_q) == (h_q - HW'(1));

  always_comb begin
    q_data_o.clear_win = restart_q;
    q_data_o.emit      = emit;
    q_data_o.last      = last;
    q_data_o.col_lo_ok = ocol_q != '0;
    q_data_o.col_hi_ok = !ocol_end;
    q_data_o.row_lo_ok = orow_q != '0;
    q_data_o.row_hi_ok = !orow_end;
    q_data_o.col       = COL_BITS'(col_q);
    q_data_o.pix       = in_frame ? in_pixel_i : '0;
  end

  // Position counters
  always_comb begin
    pos_d     = pos_q;
    col_d     = col_q;
    ocol_d    = ocol_q;
    orow_d    = orow_q;
    restart_d = restart_q;
    if (cfg_write_i) begin
      pos_d     = '0;
      col_d     = '0;
      ocol_d    = '0;
      orow_d    = '0;
      restart_d = 1'b1;
    end else if (q_push_o) begin
      restart_d = 1'b0;
      if (last) begin
        pos_d     = '0;
        col_d     = '0;
        ocol_d    = '0;
        orow_d    = '0;
        restart_d = 1'b1;
      end else begin
        pos_d = pos_q + PW'(1);
        col_d = col_end ? '0 : col_q + CW'(1);
        if (emit) begin
          if (ocol_end) begin
            ocol_d = '0;
            orow_d = orow_q + ROW_BITS'(1);
          end else begin
            ocol_d = ocol_q + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q  <= 1'b1;
      pos_q     <= '0;
      col_q     <= '0;
      ocol_q    <= '0;
      orow_q    <= '0;
      restart_q <= 1'b1;
    end else begin
      settle_q  <= cfg_write_i;
      pos_q     <= pos_d;
      col_q     <= col_d;
      ocol_q    <= ocol_d;
      orow_q    <= orow_d;
      restart_q <= restart_d;
    end
  end

endmodule

### design/nzm_queue.sv
// Small FIFO of classified items between the front and back ends.
// Depends on nzm_pkg for entry_t and QUEUE_DEPTH.
module nzm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nzm_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output nzm_pkg::entry_t head_o,
  output logic            empty_o
);
  import nzm_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);

  entry_t         slot_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q;
  logic           do_push, do_pop;

  assign full_o  = count_q == (QAW+1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QAW+1)'(1);
      end
    end
  end

endmodule

### design/nzm_back.sv
// Back end: row stores, 3x3 window, masked nonzero sum and count, mean by reciprocal.
// Depends on nzm_pkg; pops entry_t items from nzm_queue and drives the output register.
module nzm_back #(
  parameter int MAX_WIDTH = nzm_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  nzm_pkg::entry_t                   q_head_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nzm_pkg::PIXEL_BITS-1:0]    out_mean_o,
  output logic                              out_last_o
);
  import nzm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  back_state_e                    state_q, state_d;
  logic                           wr_en, shift_en, sum_en, tot_en, mul_en, load_out;
  entry_t                         cur_q;
  pixel_t                         upper_mem [MAX_WIDTH];
  pixel_t                         middle_mem [MAX_WIDTH];
  pixel_t                         rd_up_q, rd_mid_q;
  pixel_t                         win_q [WIN][WIN];   // [column][row], column 2 newest
  logic                           col_ok [WIN];
  logic                           row_ok [WIN];
  logic signed [COLSUM_BITS-1:0]  colsum_d [WIN];
  logic signed [COLSUM_BITS-1:0]  colsum_q [WIN];
  logic [1:0]                     colcnt_d [WIN];
  logic [1:0]                     colcnt_q [WIN];
  logic signed [SUM_BITS-1:0]     sum_d, abs_full;
  logic [CNT_BITS-1:0]            cnt_d;
  logic [ABS_BITS-1:0]            abs_q;
  logic [RECIP_BITS-1:0]          recip_q;
  logic                           neg_q;
  logic [PROD_BITS-1:0]           prod_q;
  logic [PIXEL_BITS:0]            quot, mean_full;
  logic                           out_valid_q, out_last_q;
  logic [PIXEL_BITS-1:0]          out_mean_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    wr_en    = 1'b0;
    shift_en = 1'b0;
    sum_en   = 1'b0;
    tot_en   = 1'b0;
    mul_en   = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = B_WIN;
        end
      end
      B_WIN: begin
        wr_en    = 1'b1;
        shift_en = 1'b1;
        state_d  = cur_q.emit ? B_SUM : B_IDLE;
      end
      B_SUM: begin
        sum_en  = 1'b1;
        state_d = B_TOT;
      end
      B_TOT: begin
        tot_en  = 1'b1;
        state_d = B_MUL;
      end
      B_MUL: begin
        mul_en  = 1'b1;
        state_d = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Row stores: read on pop, old middle moves up and new pixel goes in middle
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_up_q  <= upper_mem[q_head_i.col[CW-1:0]];
      rd_mid_q <= middle_mem[q_head_i.col[CW-1:0]];
    end
    if (wr_en) begin
      upper_mem[cur_q.col[CW-1:0]]  <= rd_mid_q;
      middle_mem[cur_q.col[CW-1:0]] <= cur_q.pix;
    end
  end

  // Current item and window shift
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end
    if (shift_en) begin
      for (int r = 0; r < WIN; r++) begin
        win_q[0][r] <= cur_q.clear_win ? '0 : win_q[1][r];
        win_q[1][r] <= cur_q.clear_win ? '0 : win_q[2][r];
      end
      win_q[2][0] <= rd_up_q;
      win_q[2][1] <= rd_mid_q;
      win_q[2][2] <= cur_q.pix;
    end
  end

  // Column sums of nonzero neighbors inside the image
  assign col_ok[0] = cur_q.col_lo_ok;
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = cur_q.col_hi_ok;
  assign row_ok[0] = cur_q.row_lo_ok;
  assign row_ok[1] = 1'b1;
  assign row_ok[2] = cur_q.row_hi_ok;

  always_comb begin
    for (int c = 0; c < WIN; c++) begin
      colsum_d[c] = '0;
      colcnt_d[c] = '0;
      for (int r = 0; r < WIN; r++) begin
        if (col_ok[c] && row_ok[r] && (win_q[c][r] != '0)) begin
          colsum_d[c] = colsum_d[c] + COLSUM_BITS'(win_q[c][r]);
          colcnt_d[c] = colcnt_d[c] + 2'd1;
        end
      end
    end
  end

  // Total, magnitude and reciprocal of the count
  always_comb begin
    sum_d    = SUM_BITS'(colsum_q[0]) + SUM_BITS'(colsum_q[1]) + SUM_BITS'(colsum_q[2]);
    cnt_d    = CNT_BITS'(colcnt_q[0]) + CNT_BITS'(colcnt_q[1]) + CNT_BITS'(colcnt_q[2]);
    abs_full = sum_d[SUM_BITS-1] ? -sum_d : sum_d;
  end

  // Quotient truncated toward zero
  assign quot      = prod_q[RECIP_SHIFT +: PIXEL_BITS+1];
  assign mean_full = neg_q ? -quot : quot;

  always_ff @(posedge clk_i) begin
    if (sum_en) begin
      for (int c = 0; c < WIN; c++) begin
        colsum_q[c] <= colsum_d[c];
        colcnt_q[c] <= colcnt_d[c];
      end
    end
    if (tot_en) begin
      abs_q   <= abs_full[ABS_BITS-1:0];
      neg_q   <= sum_d[SUM_BITS-1];
      recip_q <= recip(cnt_d);
    end
    if (mul_en) begin
      prod_q <= PROD_BITS'(abs_q) * PROD_BITS'(recip_q);
    end
    if (load_out) begin
      out_mean_q <= mean_full[PIXEL_BITS-1:0];
      out_last_q <= cur_q.last;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_mean_o  = out_mean_q;
  assign out_last_o  = out_last_q;

endmodule

### design/nonzero_mean_3x3_filter.sv
// Top level of the nonzero-mean 3x3 filter: config registers, front, queue and back.
// Depends on nzm_pkg, nzm_front, nzm_queue and nzm_back.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata = pixel_in, tuser = kind
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata = mean_out, tlast = frame_last
//  apb      | in        | psel & penable, pready tied 1  | width at 0x0, height at 0x4
//
// An item that yields a result goes through the back-end sequencer steps (row store read, window
// shift, column sums, total, multiply, output load); one without a result stops after the shift.
// A four-item queue lets the front keep accepting while the back works; ignored drains
// are accepted but not queued. s_axis_tready drops for one cycle after each register write.
// Reset clears counters, queue and output valid; row stores are not cleared.
module nonzero_mean_3x3_filter #(
  parameter int MAX_WIDTH = nzm_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [nzm_pkg::PIXEL_BITS-1:0]      s_axis_tdata,   // [15:0] pixel_in
  input  logic                                s_axis_tuser,   // [0] kind
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [nzm_pkg::PIXEL_BITS-1:0]      m_axis_tdata,   // [15:0] mean_out
  output logic                                m_axis_tlast,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nzm_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [nzm_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [nzm_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import nzm_pkg::*;

  logic [WIDTH_REG_BITS-1:0]  width_q;
  logic [HEIGHT_REG_BITS-1:0] height_q;
  logic                       cfg_write;
  reg_idx_e                   reg_sel;
  logic                       q_push, q_full, q_pop, q_empty;
  entry_t                     q_in, q_head;

  // Config registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_REG_BITS'(640);
      height_q <= HEIGHT_REG_BITS'(480);
    end else if (cfg_write) begin
      case (reg_sel)
        REG_WIDTH:  width_q  <= pwdata[WIDTH_REG_BITS-1:0];
        REG_HEIGHT: height_q <= pwdata[HEIGHT_REG_BITS-1:0];
        default:    width_q  <= width_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = APB_DATA_BITS'(width_q);
      REG_HEIGHT: prdata = APB_DATA_BITS'(height_q);
      default:    prdata = '0;
    endcase
  end

  nzm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .width_reg_i  (width_q),
    .height_reg_i (height_q),
    .cfg_write_i  (cfg_write),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_pixel_i   (pixel_t'(s_axis_tdata)),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_in)
  );

  nzm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  nzm_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_mean_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### design/nzm_checker.sv
// Port-level checks for the nonzero-mean 3x3 filter, bound to the top level.
// Depends on nzm_pkg for port widths and on nonzero_mean_3x3_filter for the bind.
module nzm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [nzm_pkg::PIXEL_BITS-1:0]      m_axis_tdata,
  input logic                                m_axis_tlast,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [nzm_pkg::APB_ADDR_BITS-1:0]   paddr,
  input logic [nzm_pkg::APB_DATA_BITS-1:0]   pwdata,
  input logic [nzm_pkg::APB_DATA_BITS-1:0]   prdata,
  input logic                                pready
);
  import nzm_pkg::*;

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // Geometry settles for a cycle after a register write
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=> !s_axis_tready)
    else $error("input accepted right after a register write");

  // Width readback right after a write
  a_width_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && !paddr[2] |=>
      (!(psel && !pwrite && !paddr[2]) ||
       prdata[WIDTH_REG_BITS-1:0] == $past(pwdata[WIDTH_REG_BITS-1:0])))
    else $error("width register readback mismatch");

  // Height readback right after a write
  a_height_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] |=>
      (!(psel && !pwrite && paddr[2]) ||
       prdata[HEIGHT_REG_BITS-1:0] == $past(pwdata[HEIGHT_REG_BITS-1:0])))
    else $error("height register readback mismatch");

endmodule

bind nonzero_mean_3x3_filter nzm_checker u_checker (.*);
